FILE: rtl/core/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg: shared constants and stage types for the half/single converter
// Bit-pattern constants of binary16 and binary32 and the records that travel
// between the pipeline stages of the converter core.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  // Direction codes
  localparam logic ACT_NARROW = 1'b0;  // single to half
  localparam logic ACT_WIDEN  = 1'b1;  // half to single

  // binary16 patterns (without sign)
  localparam logic [14:0] HALF_INF  = 15'h7c00;
  localparam logic [14:0] HALF_QNAN = 15'h7e00;
  localparam logic [14:0] HALF_ZERO = 15'h0000;

  // binary32 fields
  localparam logic [7:0]  SGL_EXP_MAX   = 8'hff;
  localparam logic [7:0]  SGL_BIAS_DIFF = 8'd112;  // 127 - 15
  localparam logic [7:0]  SGL_SUB_LOW   = 8'd102;  // below this: signed zero
  localparam logic [7:0]  SGL_SUB_HIGH  = 8'd112;  // up to this: half subnormal
  localparam logic [7:0]  SGL_OVF       = 8'd143;  // from this: half infinity
  localparam logic [7:0]  SGL_SUB_SHIFT = 8'd126;  // shift = 126 - exponent
  localparam logic [4:0]  NRM_SHIFT     = 5'd13;
  localparam logic [4:0]  HALF_EXP_MAX  = 5'h1f;

  // Stage 1: classified operand
  typedef struct packed {
    logic        fixed;      // result fully known already
    logic [31:0] fixed_val;
    logic        action;
    logic        sign;
    logic [23:0] mant;       // narrow: mantissa with hidden bit if subnormal
    logic [4:0]  sh;         // narrow: right shift amount
    logic [4:0]  expf;       // narrow: half exponent field
    logic [7:0]  wexp;       // widen: single exponent of a half subnormal
    logic [3:0]  wsh;        // widen: normalizing left shift
  } s1_t;

  // Stage 2: aligned operand with rounding bits
  typedef struct packed {
    logic        fixed;
    logic [31:0] fixed_val;
    logic        action;
    logic        sign;
    logic [4:0]  expf;
    logic [9:0]  q;          // narrow: truncated half mantissa
    logic        guard;
    logic        sticky;
    logic [7:0]  wexp;
    logic [9:0]  wmant;      // widen: normalized mantissa
  } s2_t;

endpackage

FILE: rtl/core/half_single_float_converter_core.sv
// ----------------------------------------------------------------------------
// half_single_float_converter_core: binary32 <-> binary16 converter
// Narrowing rounds to nearest even with overflow to infinity and gradual
// underflow; widening is exact and normalizes half subnormals.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   input   | start, busy (output), in_action,           | in
//           | in_single_in, in_half_in                   |
//   result  | out_valid, out_result_bits                 | out
//
// A word is taken at each edge with start high and busy low; busy stays low,
// so a new word can enter every cycle.
// The stages are classify, align and round-bit extraction, then the
// rounding increment and assembly into the output register.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// The receiver cannot stall; each result is shown for one cycle on out_valid.
// ----------------------------------------------------------------------------
module half_single_float_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_single_in,
  input  logic [15:0] in_half_in,
  output logic        out_valid,
  output logic [31:0] out_result_bits
);
  import hsfc_pkg::*;

  s1_t         s1_nxt, s1_r;
  s2_t         s2_nxt, s2_r;
  logic        v1_r, v2_r, v3_r;
  logic [31:0] res_nxt, res_r;

  // leading zeros of a 10-bit half mantissa (nonzero)
  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) n = 4'(9 - i);
    end
    return n;
  endfunction

  // Stage 1: classify
  always_comb begin
    logic [7:0]  bexp;
    logic [22:0] smant;
    logic [4:0]  hexp;
    logic [9:0]  hmant;
    logic [3:0]  lz;
    bexp  = in_single_in[30:23];
    smant = in_single_in[22:0];
    hexp  = in_half_in[14:10];
    hmant = in_half_in[9:0];
    lz    = lzc10(hmant);

    s1_nxt           = '0;
    s1_nxt.action    = in_action;
    s1_nxt.wexp      = 8'(SGL_BIAS_DIFF - {4'b0, lz});
    s1_nxt.wsh       = 4'(lz + 4'd1);
    s1_nxt.mant      = {14'b0, hmant};

    if (in_action == ACT_NARROW) begin
      s1_nxt.sign = in_single_in[31];
      if (bexp == SGL_EXP_MAX) begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = (smant == '0) ? {16'b0, in_single_in[31], HALF_INF}
                         : {16'b0, in_single_in[31], HALF_QNAN | {5'b0, smant[22:13]}};
      end else if (bexp < SGL_SUB_LOW) begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = {16'b0, in_single_in[31], HALF_ZERO};
      end else if (bexp <= SGL_SUB_HIGH) begin
        // half subnormal: shift 14..24
        s1_nxt.mant = {1'b1, smant};
        s1_nxt.sh   = 5'(SGL_SUB_SHIFT - bexp);
        s1_nxt.expf = '0;
      end else if (bexp >= SGL_OVF) begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = {16'b0, in_single_in[31], HALF_INF};
      end else begin
        s1_nxt.mant = {1'b0, smant};
        s1_nxt.sh   = NRM_SHIFT;
        s1_nxt.expf = 5'(bexp - SGL_BIAS_DIFF);
      end
    end else begin
      s1_nxt.sign = in_half_in[15];
      if (hexp == '0) begin
        // zero is fixed, subnormal goes through the normalizing shift
        s1_nxt.fixed     = (hmant == '0);
        s1_nxt.fixed_val = {in_half_in[15], 31'b0};
      end else if (hexp == HALF_EXP_MAX) begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = {in_half_in[15], SGL_EXP_MAX, hmant, 13'b0};
      end else begin
        s1_nxt.fixed     = 1'b1;
        s1_nxt.fixed_val = {in_half_in[15], 8'({3'b0, hexp} + SGL_BIAS_DIFF), hmant, 13'b0};
      end
    end
  end

  // Stage 2: align, extract guard and sticky
  always_comb begin
    logic [23:0] shifted;
    logic [23:0] low_mask;
    logic [23:0] gbits;
    logic [4:0]  gpos;
    logic [9:0]  wsh_val;
    gpos     = 5'(s1_r.sh - 5'd1);
    shifted  = s1_r.mant >> s1_r.sh;
    gbits    = s1_r.mant >> gpos;
    low_mask = (24'd1 << gpos) - 24'd1;
    wsh_val  = s1_r.mant[9:0] << s1_r.wsh;

    s2_nxt.fixed     = s1_r.fixed;
    s2_nxt.fixed_val = s1_r.fixed_val;
    s2_nxt.action    = s1_r.action;
    s2_nxt.sign      = s1_r.sign;
    s2_nxt.expf      = s1_r.expf;
    s2_nxt.q         = shifted[9:0];
    s2_nxt.guard     = gbits[0];
    s2_nxt.sticky    = |(s1_r.mant & low_mask);
    s2_nxt.wexp      = s1_r.wexp;
    s2_nxt.wmant     = wsh_val;
  end

  // Stage 3: round and assemble; a mantissa carry runs into the exponent
  always_comb begin
    logic        rnd;
    logic [14:0] mag;
    rnd = s2_r.guard & (s2_r.sticky | s2_r.q[0]);
    mag = {s2_r.expf, s2_r.q} + {14'b0, rnd};
    priority if (s2_r.fixed) begin
      res_nxt = s2_r.fixed_val;
    end else if (s2_r.action == ACT_WIDEN) begin
      res_nxt = {s2_r.sign, s2_r.wexp, s2_r.wmant, 13'b0};
    end else begin
      res_nxt = {16'b0, s2_r.sign, mag};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    res_r <= res_nxt;
  end

  assign busy            = 1'b0;
  assign out_valid       = v3_r;
  assign out_result_bits = res_r;

  // Assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("accepted word did not produce a result after 3 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without an accepted word");

  a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_NARROW) |-> ##3 (out_result_bits[31:16] == 16'h0))
    else $error("half result has nonzero upper bits");

endmodule
